// ===== design/ir_pulse_distance_frame_decoder_assert.svh =====
// ---------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder_assert.svh
// Assertion macros used by the decoder top level.
// ---------------------------------------------------------------------------
`ifndef IR_PULSE_DISTANCE_FRAME_DECODER_ASSERT_SVH
`define IR_PULSE_DISTANCE_FRAME_DECODER_ASSERT_SVH

// Check a condition at every rising clock edge outside reset.
`define IRPD_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define IRPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define IRPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/irpd_pkg.sv =====
// ---------------------------------------------------------------------------
// irpd_pkg
// Types and constants of the IR pulse-distance frame decoder.
// ---------------------------------------------------------------------------
package irpd_pkg;

    localparam int DUR_W   = 16;
    localparam int SUM_W   = DUR_W + 1;
    localparam int TICK_W  = 8;
    localparam int LIM_W   = 16;
    localparam int CMD_W   = 16;
    localparam int IDX_W   = 6;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [TICK_W-1:0] TICK_RST      = 8'd50;
    localparam logic [LIM_W-1:0]  START_MAX_RST = 16'd1579;
    localparam logic [LIM_W-1:0]  ONE_MAX_RST   = 16'd947;
    localparam logic [LIM_W-1:0]  ZERO_MAX_RST  = 16'd526;
    localparam logic [LIM_W-1:0]  PAIR_MIN_RST  = 16'd315;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICK_LENGTH = 3'd0,
        CFG_START_MAX   = 3'd1,
        CFG_ONE_MAX     = 3'd2,
        CFG_ZERO_MAX    = 3'd3,
        CFG_PAIR_MIN    = 3'd4
    } t_cfg_idx;

    // What the back end must do with one capture entry.
    typedef enum logic [2:0] {
        K_NONE  = 3'd0,
        K_START = 3'd1,
        K_DATA  = 3'd2,
        K_CLOSE = 3'd3,
        K_EXTRA = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [SUM_W-1:0] value;
        logic             last;
    } t_item;

    typedef struct packed {
        logic [TICK_W-1:0] tick_length_us;
        logic [LIM_W-1:0]  start_stop_max_us;
        logic [LIM_W-1:0]  one_max_us;
        logic [LIM_W-1:0]  zero_max_us;
        logic [LIM_W-1:0]  pair_min_us;
    } t_cfg;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_stat;

endpackage

// ===== design/irpd_in_if.sv =====
// ---------------------------------------------------------------------------
// irpd_in_if
// Capture entry channel: one duration word per transfer.
// ---------------------------------------------------------------------------
interface irpd_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] duration_ticks;
    logic        last_entry;

    modport source (output valid, duration_ticks, last_entry, input ready);
    modport sink   (input valid, duration_ticks, last_entry, output ready);
endinterface

// ===== design/irpd_out_if.sv =====
// ---------------------------------------------------------------------------
// irpd_out_if
// Decode result channel: one word per finished capture.
// ---------------------------------------------------------------------------
interface irpd_out_if;
    logic        valid;
    logic        ready;
    logic        decoded;
    logic [15:0] command;

    modport source (output valid, decoded, command, input ready);
    modport sink   (input valid, decoded, command, output ready);
endinterface

// ===== design/irpd_front.sv =====
// ---------------------------------------------------------------------------
// irpd_front
// Entry classifier: tracks position in the capture and pairs marks/spaces.
// ---------------------------------------------------------------------------
module irpd_front
    import irpd_pkg::*;
#(
    parameter int DATA_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    irpd_in_if.sink           i_in,
    input  logic              i_q_full,
    output logic              o_push,
    output t_item             o_item
);

    localparam logic [IDX_W-1:0] END_IDX = IDX_W'(2 * DATA_BITS + 3);
    localparam logic [IDX_W-1:0] START_IDX = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

    logic [IDX_W-1:0] r_idx;
    logic [DUR_W-1:0] r_pend;
    logic             w_accept;

    assign i_in.ready = !i_q_full;
    assign w_accept   = i_in.valid && !i_q_full;
    assign o_push     = w_accept;

    always_comb begin
        o_item.last  = i_in.last_entry;
        o_item.value = {1'b0, i_in.duration_ticks};
        o_item.kind  = K_NONE;
        if (r_idx == '0) begin
            o_item.kind = K_NONE;
        end else if (r_idx < END_IDX && r_idx[0]) begin
            o_item.kind = K_NONE;
        end else if (r_idx < END_IDX) begin
            o_item.kind  = (r_idx == START_IDX) ? K_START : K_DATA;
            o_item.value = SUM_W'(r_pend) + SUM_W'(i_in.duration_ticks);
        end else if (r_idx == END_IDX) begin
            o_item.kind = K_CLOSE;
        end else begin
            o_item.kind = K_EXTRA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_pend <= '0;
        end else if (w_accept) begin
            if (i_in.last_entry) begin
                r_idx  <= '0;
                r_pend <= '0;
            end else begin
                if (r_idx != IDX_MAX) begin
                    r_idx <= r_idx + 1'b1;
                end
                // hold the mark until its space arrives
                if (r_idx < END_IDX && r_idx[0]) begin
                    r_pend <= i_in.duration_ticks;
                end
            end
        end
    end

endmodule

// ===== design/irpd_queue.sv =====
// ---------------------------------------------------------------------------
// irpd_queue
// Two-entry queue between the classifier and the decode back end.
// ---------------------------------------------------------------------------
module irpd_queue
    import irpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output logic    o_valid,
    output t_item   o_item,
    output t_q_stat o_stat
);

    t_item                r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 w_push;
    logic                 w_pop;

    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;
    assign o_valid      = !o_stat.empty;
    assign o_item       = r_mem[r_rd_ptr];
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/irpd_back.sv =====
// ---------------------------------------------------------------------------
// irpd_back
// Decode back end: scales pair sums, checks limits, shifts in data bits.
// ---------------------------------------------------------------------------
module irpd_back
    import irpd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_valid,
    input  t_item     i_item,
    output logic      o_pop,
    irpd_out_if.source o_out
);

    localparam int PROD_W = SUM_W + TICK_W;

    logic [PROD_W-1:0] w_prod;
    logic [LIM_W-1:0]  w_us;
    logic [CMD_W-1:0]  r_shift;
    logic              r_failed;
    logic              r_out_valid;
    logic              r_decoded;
    logic [CMD_W-1:0]  r_command;
    logic [CMD_W-1:0]  n_shift;
    logic              n_failed;
    logic              w_ok;

    assign w_prod = PROD_W'(i_item.value) * PROD_W'(i_cfg.tick_length_us);
    // saturate instead of wrapping
    assign w_us   = (|w_prod[PROD_W-1:LIM_W]) ? {LIM_W{1'b1}} : w_prod[LIM_W-1:0];

    // a result word may only be produced when the output register frees up
    assign o_pop = i_q_valid && (!i_item.last || !r_out_valid || o_out.ready);

    always_comb begin
        n_shift  = r_shift;
        n_failed = r_failed;
        case (i_item.kind)
            K_START: begin
                if (!(w_us > i_cfg.one_max_us && w_us <= i_cfg.start_stop_max_us)) begin
                    n_failed = 1'b1;
                end
            end
            K_DATA: begin
                if (w_us >= i_cfg.pair_min_us && w_us <= i_cfg.zero_max_us) begin
                    n_shift = {r_shift[CMD_W-2:0], 1'b0};
                end else if (w_us > i_cfg.zero_max_us && w_us <= i_cfg.one_max_us) begin
                    n_shift = {r_shift[CMD_W-2:0], 1'b1};
                end else begin
                    n_failed = 1'b1;
                end
            end
            K_CLOSE: begin
                if (!(w_us < i_cfg.pair_min_us)) begin
                    n_failed = 1'b1;
                end
            end
            K_EXTRA: n_failed = 1'b1;
            default: ;
        endcase
    end

    assign w_ok = !n_failed && (i_item.kind == K_CLOSE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= '0;
            r_failed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_item.last) begin
                    r_shift  <= '0;
                    r_failed <= 1'b0;
                end else begin
                    r_shift  <= n_shift;
                    r_failed <= n_failed;
                end
            end
            if (o_pop && i_item.last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.last) begin
            r_decoded <= w_ok;
            r_command <= w_ok ? n_shift : '0;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.decoded = r_decoded;
    assign o_out.command = r_command;

endmodule

// ===== design/ir_pulse_distance_frame_decoder.sv =====
// ---------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder
// Pulse-distance IR frame decoder, one capture entry per word.
// ---------------------------------------------------------------------------
// Feed the raw capture one duration word at a time, last_entry set on the
// final word; one result word (decoded flag and command) follows each final
// word. The block takes one entry per clock while input ready is high. The
// classifier registers each entry into a two-entry queue, and the back end
// scales it (one 17x8 multiply), checks it and shifts the data bit in when
// it pops the entry; the result word is registered on the output. Input
// ready drops only when the queue is full, i.e. when a result word waits on
// the output, the next final entry waits at the head of the queue and one
// more entry sits behind it. The user must write limits through the config
// port only while no capture is in flight; the block does not enforce it.
// ---------------------------------------------------------------------------
`include "ir_pulse_distance_frame_decoder_assert.svh"

module ir_pulse_distance_frame_decoder
    import irpd_pkg::*;
#(
    parameter int DATA_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    irpd_in_if.sink              i_in,
    irpd_out_if.source           o_out
);

    t_cfg    r_cfg;
    logic    w_push;
    t_item   w_push_item;
    logic    w_q_valid;
    t_item   w_q_item;
    logic    w_pop;
    t_q_stat w_q_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_length_us    <= TICK_RST;
            r_cfg.start_stop_max_us <= START_MAX_RST;
            r_cfg.one_max_us        <= ONE_MAX_RST;
            r_cfg.zero_max_us       <= ZERO_MAX_RST;
            r_cfg.pair_min_us       <= PAIR_MIN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TICK_LENGTH: r_cfg.tick_length_us    <= i_cfg_data[TICK_W-1:0];
                CFG_START_MAX:   r_cfg.start_stop_max_us <= i_cfg_data[LIM_W-1:0];
                CFG_ONE_MAX:     r_cfg.one_max_us        <= i_cfg_data[LIM_W-1:0];
                CFG_ZERO_MAX:    r_cfg.zero_max_us       <= i_cfg_data[LIM_W-1:0];
                CFG_PAIR_MIN:    r_cfg.pair_min_us       <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    irpd_front #(
        .DATA_BITS (DATA_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_q_stat.full),
        .o_push   (w_push),
        .o_item   (w_push_item)
    );

    irpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .o_stat  (w_q_stat)
    );

    irpd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_item    (w_q_item),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

    `IRPD_ASSERT_ALWAYS(a_q_count_bound, i_clk, i_rst_n, w_q_stat.count <= Q_CNT_W'(Q_DEPTH), "queue count exceeds depth")
    `IRPD_ASSERT_IMPLY(a_fail_clears_cmd, i_clk, i_rst_n, o_out.valid && !o_out.decoded, o_out.command == '0, "undecoded result carries a command")
    `IRPD_ASSERT_NEXT(a_push_fills_q, i_clk, i_rst_n, w_push && !w_pop, !w_q_stat.empty, "pushed word lost from queue")

endmodule
